[sv/nps_pkg.sv]
// Shared types and constants for the nonpreemptive priority scheduler.
package nps_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int TIME_W        = 21;
  localparam logic [TIME_W-1:0] TIME_MAX = TIME_W'(2097151);
  localparam int PN_W          = 5;

  typedef struct packed {
    logic [15:0] arrival_time;
    logic [15:0] burst_time;
    logic [7:0]  prio_level;
    logic        last_process;
  } load_t;

  typedef struct packed {
    logic [PN_W-1:0]   process_number;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic              last_result;
  } result_t;

  typedef struct packed {
    logic [15:0] arr;
    logic [15:0] burst;
    logic [7:0]  prio;
  } entry_t;

  // scan results handed from the compare unit to the sequencer
  typedef struct packed {
    logic        rdy_found;
    logic [15:0] rdy_arr;
    logic [15:0] rdy_burst;
    logic        min_found;
    logic [15:0] min_arr;
    logic [15:0] min_burst;
  } pick_t;

endpackage

[sv/nps_store.sv]
// Process table memory: one write port, one registered read port.
module nps_store #(
  parameter int MAX_PROCS = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MAX_PROCS)-1:0] waddr,
  input  nps_pkg::entry_t              wdata,
  input  logic [$clog2(MAX_PROCS)-1:0] raddr,
  output nps_pkg::entry_t              rdata
);
  import nps_pkg::*;

  entry_t mem [MAX_PROCS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/nps_pick.sv]
// Shared compare unit: folds one table entry per cycle into the running best picks.
module nps_pick #(
  parameter int MAX_PROCS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         vld,
  input  logic [$clog2(MAX_PROCS)-1:0] idx,
  input  nps_pkg::entry_t              ent,
  input  logic                         done_bit,
  input  logic [nps_pkg::TIME_W-1:0]   cur,
  output nps_pkg::pick_t               pk,
  output logic [$clog2(MAX_PROCS)-1:0] rdy_idx,
  output logic [$clog2(MAX_PROCS)-1:0] min_idx
);
  import nps_pkg::*;

  logic [7:0] rdy_prio;
  logic [7:0] min_prio;
  logic       ready;
  logic       rdy_better;
  logic       min_better;

  always_comb begin
    ready      = !done_bit && (TIME_W'(ent.arr) <= cur);
    // lower priority value, then earlier arrival; equal keeps the earlier load
    rdy_better = !pk.rdy_found || (ent.prio < rdy_prio) ||
                 ((ent.prio == rdy_prio) && (ent.arr < pk.rdy_arr));
    // idle fallback: earliest arrival, then lowest priority value
    min_better = !pk.min_found || (ent.arr < pk.min_arr) ||
                 ((ent.arr == pk.min_arr) && (ent.prio < min_prio));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pk.rdy_found <= 1'b0;
      pk.min_found <= 1'b0;
    end else if (clr) begin
      pk.rdy_found <= 1'b0;
      pk.min_found <= 1'b0;
    end else if (vld) begin
      if (ready && rdy_better) begin
        pk.rdy_found <= 1'b1;
        pk.rdy_arr   <= ent.arr;
        pk.rdy_burst <= ent.burst;
        rdy_prio     <= ent.prio;
        rdy_idx      <= idx;
      end
      if (!done_bit && min_better) begin
        pk.min_found <= 1'b1;
        pk.min_arr   <= ent.arr;
        pk.min_burst <= ent.burst;
        min_prio     <= ent.prio;
        min_idx      <= idx;
      end
    end
  end

endmodule

[sv/nonpreemptive_priority_scheduler.sv]
// Top level: loads a process set, then schedules it nonpreemptively by priority.
//
//   channel  dir  handshake                payload
//   load     in   load_valid / load_stall   load (nps_pkg::load_t)
//   res      out  res_valid / res_stall     res  (nps_pkg::result_t)
//
// Loading accepts one beat per cycle while load_stall is low. For each result,
// the compare unit scans the whole table through the single memory read port,
// then the drain, completion, turnaround and emit steps follow. Reset clears
// control and done flags; the table needs no clear. A stalled result holds the
// emit step; load_stall stays high while scheduling.
module nonpreemptive_priority_scheduler #(
  parameter int MAX_PROCS = nps_pkg::MAX_PROCS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_stall,
  input  nps_pkg::load_t   load,
  output logic             res_valid,
  input  logic             res_stall,
  output nps_pkg::result_t res
);
  import nps_pkg::*;

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_COMP,
    S_TAT,
    S_EMIT
  } state_t;

  state_t              st;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       k;
  logic [IW-1:0]       scan;
  logic                rd_vld;
  logic [IW-1:0]       rd_idx;
  logic [MAX_PROCS-1:0] done;
  logic [TIME_W-1:0]   cur;
  logic [IW-1:0]       sel_idx;
  logic [15:0]         sel_arr;
  logic [15:0]         sel_burst;
  logic [TIME_W-1:0]   comp;
  logic [TIME_W-1:0]   tat;

  entry_t              wdata;
  entry_t              rdata;
  pick_t               pk;
  logic [IW-1:0]       rdy_idx;
  logic [IW-1:0]       min_idx;

  logic                load_fire;
  logic                full;
  logic [CW-1:0]       cnt_m1;
  logic                scan_end;
  logic                last_k;
  logic                res_take;
  logic [IW-1:0]       use_idx;
  logic [15:0]         use_arr;
  logic [15:0]         use_burst;
  logic [TIME_W-1:0]   start;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   comp_next;
  logic [TIME_W-1:0]   tat_next;
  logic [TIME_W-1:0]   wt_next;
  logic [IW:0]         pnum;

  assign load_stall = (st != S_LOAD);

  always_comb begin
    load_fire = load_valid && (st == S_LOAD);
    full      = (cnt == CW'(MAX_PROCS - 1));
    cnt_m1    = cnt - 1'b1;
    scan_end  = (scan == cnt_m1[IW-1:0]);
    last_k    = (k == cnt_m1);
    res_take  = !res_valid || !res_stall;
    wdata.arr   = load.arrival_time;
    wdata.burst = load.burst_time;
    wdata.prio  = load.prio_level;
    // nothing ready: time jumps to the earliest pending arrival
    use_idx   = pk.rdy_found ? rdy_idx      : min_idx;
    use_arr   = pk.rdy_found ? pk.rdy_arr   : pk.min_arr;
    use_burst = pk.rdy_found ? pk.rdy_burst : pk.min_burst;
    start     = pk.rdy_found ? cur : TIME_W'(pk.min_arr);
    sum       = {1'b0, start} + (TIME_W + 1)'(use_burst);
    comp_next = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    tat_next  = comp - TIME_W'(sel_arr);
    wt_next   = (tat >= TIME_W'(sel_burst)) ? (tat - TIME_W'(sel_burst)) : '0;
    pnum      = {1'b0, sel_idx} + 1'b1;
  end

  nps_store #(.MAX_PROCS(MAX_PROCS)) u_store (
    .clk  (clk),
    .we   (load_fire),
    .waddr(cnt[IW-1:0]),
    .wdata(wdata),
    .raddr(scan),
    .rdata(rdata)
  );

  nps_pick #(.MAX_PROCS(MAX_PROCS)) u_pick (
    .clk     (clk),
    .rst     (rst),
    .clr     ((st == S_SCAN) && (scan == '0)),
    .vld     (rd_vld),
    .idx     (rd_idx),
    .ent     (rdata),
    .done_bit(done[rd_idx]),
    .cur     (cur),
    .pk      (pk),
    .rdy_idx (rdy_idx),
    .min_idx (min_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_LOAD;
      cnt       <= '0;
      k         <= '0;
      scan      <= '0;
      rd_vld    <= 1'b0;
      done      <= '0;
      cur       <= '0;
      res_valid <= 1'b0;
    end else begin
      rd_vld <= (st == S_SCAN);
      rd_idx <= scan;
      // the emit step refills the output register itself
      if (res_valid && !res_stall && (st != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      case (st)
        S_LOAD: begin
          if (load_valid) begin
            cnt <= cnt + 1'b1;
            if (load.last_process || full) begin
              st   <= S_SCAN;
              scan <= '0;
              k    <= '0;
              cur  <= '0;
            end
          end
        end
        S_SCAN: begin
          scan <= scan + 1'b1;
          if (scan_end) begin
            st <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          st <= S_COMP;
        end
        S_COMP: begin
          sel_idx       <= use_idx;
          sel_arr       <= use_arr;
          sel_burst     <= use_burst;
          comp          <= comp_next;
          cur           <= comp_next;
          done[use_idx] <= 1'b1;
          st            <= S_TAT;
        end
        S_TAT: begin
          tat <= tat_next;
          st  <= S_EMIT;
        end
        S_EMIT: begin
          if (res_take) begin
            res_valid           <= 1'b1;
            res.process_number  <= PN_W'(pnum);
            res.completion_time <= comp;
            res.turnaround_time <= tat;
            res.waiting_time    <= wt_next;
            res.last_result     <= last_k;
            if (last_k) begin
              st   <= S_LOAD;
              cnt  <= '0;
              done <= '0;
              cur  <= '0;
            end else begin
              k    <= k + 1'b1;
              scan <= '0;
              st   <= S_SCAN;
            end
          end
        end
        default: begin
          st <= S_LOAD;
        end
      endcase
    end
  end

  // every finished process has produced exactly one result beat
  a_done_count: assert property (@(posedge clk) disable iff (rst)
    (st == S_SCAN) |-> ($countones(done) == int'(k)))
    else $error("done flag count differs from results issued");

  // an unfinished process always remains while results are pending
  a_min_found: assert property (@(posedge clk) disable iff (rst)
    (st == S_COMP) |-> pk.min_found)
    else $error("no pending process found by scan");

  a_sel_fresh: assert property (@(posedge clk) disable iff (rst)
    (st == S_COMP) |-> !done[use_idx])
    else $error("scheduled a finished process");

  a_rdy_arrived: assert property (@(posedge clk) disable iff (rst)
    ((st == S_COMP) && pk.rdy_found) |-> (TIME_W'(pk.rdy_arr) <= cur))
    else $error("ready pick has not arrived yet");

endmodule
